// ===== rtl/core/keyframe_segment_locator_macros.svh =====
// Assertion macros shared by the keyframe segment locator modules.
`ifndef KEYFRAME_SEGMENT_LOCATOR_MACROS_SVH
`define KEYFRAME_SEGMENT_LOCATOR_MACROS_SVH

// Implication checked on every clock edge outside reset.
`define KSL_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define KSL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/ksl_pkg.sv =====
// Package with types, constants and command codes of the keyframe segment locator.
`timescale 1ns / 1ps
package ksl_pkg;

  localparam int MaxKeys  = 16;
  localparam int IdxW     = $clog2(MaxKeys);
  localparam int CntW     = IdxW + 1;
  localparam int KeyW     = 31;
  localparam int TimeW    = 32;
  localparam int FracW    = 16;

  localparam logic [1:0] StatusInside = 2'd0;
  localparam logic [1:0] StatusPastEnd = 2'd1;
  localparam logic [1:0] StatusBefore = 2'd2;

  localparam logic [0:0] RegCyclic = 1'd0;
  localparam logic [0:0] RegKeyCount = 1'd1;

  typedef struct packed {
    logic                    action;
    logic [3:0]              key_slot;
    logic [KeyW-1:0]         key_time;
    logic signed [TimeW-1:0] query_time;
  } in_word_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [3:0]       last_index;
    logic [3:0]       next_index;
    logic [FracW-1:0] fraction;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;       // capture input word, clear iteration state
    logic wr_key;     // write key table
    logic rd_period;  // read last key for wrap
    logic mod_start;  // set up modulo
    logic mod_step;   // one restoring modulo step
    logic mod_fix;    // floor correction
    logic scan_rd;    // read key at scan index
    logic scan_step;  // compare and advance
    logic div_setup;  // read lower bounding key
    logic div_init;   // latch lower key, read upper key
    logic div_step;   // form numerator and divisor, then one quotient bit
    logic out_load;   // load result register
  } ksl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic cyclic;
    logic period_zero;
    logic mod_done;
    logic scan_hit;   // key above time found
    logic scan_end;   // index reached key count
    logic div_done;
  } ksl_stat_t;

endpackage

// ===== rtl/core/keyframe_segment_locator.sv =====
// Top level of the keyframe segment locator.
`timescale 1ns / 1ps
// Keyframe segment locator: a write word stores one Q15.16 key in a 16-entry
// table and gives no result. A query word finds the segment that holds its
// time and returns the bounding indices and a Q0.16 fraction. In cyclic mode
// the time is first reduced modulo the last key in use by a one-bit-per-cycle
// restoring modulo (skipped, with the time set to zero, when the last key is
// zero). The scan reads keys one by one through the single read port of the
// key table and stops on the first key above the time or runs past all keys
// in use; the fraction comes from a 16-step restoring divider. One word is
// processed at a time; the next word may be taken while a result waits, and
// a finished query stalls until that result has been taken.
module keyframe_segment_locator import ksl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  in_word_t   in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output out_word_t  out_data,
  input  logic       cfg_we,
  input  logic [0:0] cfg_idx,
  input  logic [4:0] cfg_data
);

  ksl_cmd_t  cmd;
  ksl_stat_t stat;
  out_word_t res;

  ksl_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready, .in_action(in_data.action),
    .out_valid, .out_ready, .stat, .cmd
  );

  ksl_datapath u_dp (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_data, .in_word(in_data),
    .cmd, .stat, .res
  );

  // Result register, captured on result load.
  out_word_t res_hold_r;
  always_ff @(posedge clk) begin
    if (cmd.out_load) res_hold_r <= res;
  end
  assign out_data = res_hold_r;

endmodule

// ===== rtl/core/ksl_datapath.sv =====
// Datapath of the keyframe segment locator: key table, modulo, scan and divider.
`timescale 1ns / 1ps
`include "keyframe_segment_locator_macros.svh"
module ksl_datapath import ksl_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_idx,
  input  logic [4:0]  cfg_data,
  input  in_word_t    in_word,
  input  ksl_cmd_t    cmd,
  output ksl_stat_t   stat,
  output out_word_t   res
);

  // Key table memory with registered read.
  logic [KeyW-1:0] key_mem [MaxKeys];
  logic [KeyW-1:0] rd_data_r;
  logic [IdxW-1:0] rd_addr;

  logic            cyclic_r;
  logic [4:0]      key_count_r;
  logic [CntW-1:0] n_use;

  in_word_t        word_r;
  logic signed [TimeW:0] t_r, t_nxt;     // working time, 33 bits signed
  logic [KeyW-1:0] period_r;
  logic [TimeW-1:0] mag_r;               // magnitude being reduced
  logic [KeyW:0]   rem_r;                // partial remainder
  logic [5:0]      bit_cnt_r;
  logic            neg_r;
  logic [CntW-1:0] idx_r;
  logic [KeyW-1:0] lo_key_r;
  logic [KeyW:0]   num_r;
  logic [KeyW:0]   den_r;
  logic [FracW-1:0] quo_r;
  logic [4:0]      div_cnt_r;
  logic [1:0]      status_sel;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cyclic_r    <= 1'b0;
      key_count_r <= 5'd2;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        RegCyclic:   cyclic_r <= cfg_data[0];
        RegKeyCount: key_count_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Clamp the key count into 2..MaxKeys.
  always_comb begin
    if (key_count_r < 5'd2) n_use = CntW'(2);
    else if (32'(key_count_r) > MaxKeys) n_use = CntW'(MaxKeys);
    else n_use = CntW'(key_count_r);
  end

  // Read address selection.
  always_comb begin
    rd_addr = idx_r[IdxW-1:0];
    if (cmd.rd_period) rd_addr = IdxW'(n_use - CntW'(1));
    else if (cmd.div_setup) rd_addr = IdxW'(idx_r - CntW'(1));
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_key) key_mem[word_r.key_slot[IdxW-1:0]] <= word_r.key_time;
    rd_data_r <= key_mem[rd_addr];
  end

  // Restoring modulo step on the magnitude.
  logic [KeyW+1:0] rem_sh;
  logic [KeyW+1:0] rem_sub;
  assign rem_sh  = {rem_r, mag_r[TimeW-1]};
  assign rem_sub = rem_sh - {2'b00, period_r};

  // Divider step.
  logic [KeyW+1:0] num_sh;
  logic [KeyW+1:0] num_sub;
  assign num_sh  = {num_r, 1'b0};
  assign num_sub = num_sh - {1'b0, den_r};

  logic signed [TimeW:0] key_ext;
  assign key_ext = $signed({2'b00, rd_data_r});

  always_comb begin
    t_nxt = t_r;
    if (cmd.load) t_nxt = {in_word.query_time[TimeW-1], in_word.query_time};
    else if (cmd.mod_start && rd_data_r == '0) t_nxt = '0;
    else if (cmd.mod_fix) begin
      if (neg_r && rem_r != '0) t_nxt = $signed({2'b00, period_r - rem_r[KeyW-1:0]});
      else t_nxt = $signed({2'b00, rem_r[KeyW-1:0]});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r     <= '0;
      bit_cnt_r <= '0;
      div_cnt_r <= '0;
    end else begin
      t_r <= t_nxt;
      if (cmd.load) begin
        word_r <= in_word;
        idx_r  <= '0;
      end
      if (cmd.rd_period) period_r <= '0;
      if (cmd.mod_start) begin
        period_r  <= rd_data_r;
        neg_r     <= t_r[TimeW];
        mag_r     <= t_r[TimeW] ? TimeW'(-t_r) : TimeW'(t_r);
        rem_r     <= '0;
        bit_cnt_r <= '0;
      end
      if (cmd.mod_step) begin
        if (!rem_sub[KeyW+1]) rem_r <= rem_sub[KeyW:0];
        else rem_r <= rem_sh[KeyW:0];
        mag_r     <= {mag_r[TimeW-2:0], 1'b0};
        bit_cnt_r <= bit_cnt_r + 6'd1;
      end
      if (cmd.scan_step && !(t_r < key_ext)) idx_r <= idx_r + CntW'(1);
      if (cmd.div_init) lo_key_r <= rd_data_r;
      if (cmd.div_step && div_cnt_r == 5'd0) begin
        // numerator formed from time and lower key, divisor from upper and lower key
        num_r <= 32'(t_r) - {1'b0, lo_key_r};
        den_r <= {1'b0, rd_data_r} - {1'b0, lo_key_r};
        quo_r <= '0;
        div_cnt_r <= 5'd1;
      end else if (cmd.div_step) begin
        if (!num_sub[KeyW+1]) begin
          num_r <= num_sub[KeyW:0];
          quo_r <= {quo_r[FracW-2:0], 1'b1};
        end else begin
          num_r <= num_sh[KeyW:0];
          quo_r <= {quo_r[FracW-2:0], 1'b0};
        end
        div_cnt_r <= div_cnt_r + 5'd1;
      end
      if (cmd.load) div_cnt_r <= '0;
    end
  end

  // Result formation from scan outcome.
  always_comb begin
    if (idx_r == '0) status_sel = StatusBefore;
    else if (idx_r == n_use) status_sel = StatusPastEnd;
    else status_sel = StatusInside;
    res.status     = status_sel;
    res.last_index = '0;
    res.next_index = '0;
    res.fraction   = '0;
    unique case (status_sel)
      StatusPastEnd: begin
        res.last_index = 4'(n_use - CntW'(1));
        res.next_index = 4'(n_use - CntW'(1));
      end
      StatusInside: begin
        res.last_index = 4'(idx_r - CntW'(1));
        res.next_index = 4'(idx_r);
        res.fraction   = quo_r;
      end
      default: ;
    endcase
  end

  assign stat.cyclic      = cyclic_r;
  assign stat.period_zero = (rd_data_r == '0);
  assign stat.mod_done    = (bit_cnt_r == 6'(TimeW));
  assign stat.scan_hit    = (t_r < key_ext);
  assign stat.scan_end    = (idx_r == n_use);
  assign stat.div_done    = (div_cnt_r == 5'(FracW + 1));

  `KSL_ASSERT_IMP(a_idx_range, clk, rst_n, cmd.scan_rd, idx_r <= n_use, "scan index past key count")
  `KSL_ASSERT_NEXT(a_mod_count, clk, rst_n, cmd.mod_start, bit_cnt_r == '0,
    "modulo counter not cleared")
  `KSL_ASSERT_IMP(a_div_count, clk, rst_n, 1'b1, div_cnt_r <= 5'(FracW + 1),
    "divider overran")

endmodule

// ===== rtl/core/ksl_ctrl.sv =====
// Controller state machine of the keyframe segment locator.
`timescale 1ns / 1ps
`include "keyframe_segment_locator_macros.svh"
module ksl_ctrl import ksl_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic      in_action,
  output logic      out_valid,
  input  logic      out_ready,
  input  ksl_stat_t stat,
  output ksl_cmd_t  cmd
);

  localparam logic [3:0] SIdle   = 4'd0;
  localparam logic [3:0] SDecode = 4'd1;
  localparam logic [3:0] SPer    = 4'd2;
  localparam logic [3:0] SModSt  = 4'd3;
  localparam logic [3:0] SMod    = 4'd4;
  localparam logic [3:0] SFix    = 4'd5;
  localparam logic [3:0] SRd     = 4'd6;
  localparam logic [3:0] SCmp    = 4'd7;
  localparam logic [3:0] SLoRd   = 4'd8;
  localparam logic [3:0] SHiRd   = 4'd9;
  localparam logic [3:0] SDiv    = 4'd10;
  localparam logic [3:0] SDone   = 4'd11;

  logic [3:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       act_r;

  // Input is taken in idle; a waiting result stays in the output register.
  assign in_ready  = (state_r == SIdle);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd           = '0;
    unique case (state_r)
      SIdle: if (in_valid && in_ready) begin
        cmd.load  = 1'b1;
        state_nxt = SDecode;
      end
      SDecode: begin
        if (!act_r) begin
          cmd.wr_key = 1'b1;
          state_nxt  = SIdle;
        end else if (stat.cyclic) begin
          cmd.rd_period = 1'b1;
          state_nxt     = SPer;
        end else state_nxt = SRd;
      end
      SPer: begin
        cmd.mod_start = 1'b1;
        state_nxt     = stat.period_zero ? SRd : SMod;
      end
      SMod: begin
        if (stat.mod_done) begin
          cmd.mod_fix = 1'b1;
          state_nxt   = SRd;
        end else cmd.mod_step = 1'b1;
      end
      SRd: begin
        cmd.scan_rd = 1'b1;
        state_nxt   = stat.scan_end ? SDone : SCmp;
      end
      SCmp: begin
        if (stat.scan_hit) state_nxt = SLoRd;
        else begin
          cmd.scan_step = 1'b1;
          state_nxt     = SRd;
        end
      end
      SLoRd: begin
        cmd.div_setup = 1'b1;
        state_nxt     = SHiRd;
      end
      SHiRd: begin
        cmd.div_init = 1'b1;
        state_nxt    = SDiv;
      end
      SDiv: begin
        if (stat.div_done) state_nxt = SDone;
        else cmd.div_step = 1'b1;
      end
      SDone: begin
        if (!out_valid_r) begin
          cmd.out_load  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = SIdle;
        end
      end
      default: state_nxt = SIdle;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= SIdle;
      out_valid_r <= 1'b0;
      act_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (cmd.load) act_r <= in_action;
    end
  end

  `KSL_ASSERT_NEXT(a_load_leaves_idle, clk, rst_n, cmd.load, state_r == SDecode,
    "load did not start decode")
  `KSL_ASSERT_IMP(a_no_accept_busy, clk, rst_n, in_ready, state_r == SIdle,
    "input taken while busy")
  `KSL_ASSERT_NEXT(a_out_raise, clk, rst_n, cmd.out_load, out_valid_r,
    "result not presented")

endmodule
